[design/imucf_pkg.sv]
// shared types, constants and the cordic step-angle table for the
// imu complementary filter; no dependencies
package imucf_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 16;
   localparam int CORDIC_STEPS_DEF    = 16;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_GAIN   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_WEIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_LOW     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_HIGH    = 4'd3;

   localparam logic [15:0] GYRO_GAIN_RST   = 16'd280;
   localparam logic [16:0] KEEP_WEIGHT_RST = 17'd64225;
   localparam logic [16:0] MAG_LOW_RST     = 17'd1024;
   localparam logic [16:0] MAG_HIGH_RST    = 17'd32768;
   localparam logic [16:0] KEEP_MAX        = 17'd65536;

   localparam int TAB_LEN  = 24;
   localparam int TAB_FRAC = 24;

   typedef struct packed {
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_z;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_data_type;

   typedef struct packed {
      logic signed [19:0] pitch_tenths;
      logic signed [19:0] roll_tenths;
      logic               correction_applied;
   } rsp_data_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_GYRO_X,
      MUL_GYRO_Z,
      MUL_KEEP,
      MUL_ACC,
      MUL_TEN_P,
      MUL_TEN_R
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        corr_eval;
      mul_sel_type mul_sel;
      logic        pitch_gyro_upd;
      logic        roll_gyro_upd;
      logic        cordic_load;
      logic        cordic_roll;
      logic        cordic_step;
      logic        blend_first;
      logic        blend_upd;
      logic        blend_roll;
      logic        pitch_t_load;
      logic        emit;
   } dp_cmd_type;

   typedef struct packed {
      logic corr;
   } dp_status_type;

   // atan(2^-i) in degrees, 24 fraction bits
   function automatic logic [31:0] step_deg_q24(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'd754974720;
         5'd1:    v = 32'd445687602;
         5'd2:    v = 32'd235489088;
         5'd3:    v = 32'd119537938;
         5'd4:    v = 32'd60000934;
         5'd5:    v = 32'd30029717;
         5'd6:    v = 32'd15018523;
         5'd7:    v = 32'd7509720;
         5'd8:    v = 32'd3754917;
         5'd9:    v = 32'd1877466;
         5'd10:   v = 32'd938734;
         5'd11:   v = 32'd469367;
         5'd12:   v = 32'd234684;
         5'd13:   v = 32'd117342;
         5'd14:   v = 32'd58671;
         5'd15:   v = 32'd29335;
         5'd16:   v = 32'd14668;
         5'd17:   v = 32'd7334;
         5'd18:   v = 32'd3667;
         5'd19:   v = 32'd1833;
         5'd20:   v = 32'd917;
         5'd21:   v = 32'd458;
         5'd22:   v = 32'd229;
         5'd23:   v = 32'd115;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // step angle rounded to the angle format; a format with 24 or more fraction bits gets the table value unshifted
   function automatic logic [31:0] step_angle(input logic [4:0] idx, input int frac);
      logic [32:0] t;
      int          sh;
      t = {1'b0, step_deg_q24(idx)};
      if (frac >= TAB_FRAC) begin
         return t[31:0];
      end
      sh = TAB_FRAC - frac;
      t  = (t + (33'd1 << (sh - 1))) >> sh;
      return t[31:0];
   endfunction

endpackage

[design/imucf_ctrl.sv]
// sequencer for the imu complementary filter: gyro update, two cordic runs and
// blends (only with accelerometer correction), tenths conversion and the result word handshake; uses imucf_pkg
module imucf_ctrl #(
   parameter int CORDIC_STEPS = imucf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  imucf_pkg::dp_status_type      status,
   output imucf_pkg::dp_cmd_type         cmd,
   output logic [$clog2(CORDIC_STEPS)-1:0] step_idx
);
   import imucf_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_GYRO_P    = 11'b000_0000_0010,
      ST_GYRO_R    = 11'b000_0000_0100,
      ST_GYRO_DONE = 11'b000_0000_1000,
      ST_CORDIC    = 11'b000_0001_0000,
      ST_BLEND_A   = 11'b000_0010_0000,
      ST_BLEND_B   = 11'b000_0100_0000,
      ST_BLEND_C   = 11'b000_1000_0000,
      ST_TEN_P     = 11'b001_0000_0000,
      ST_TEN_R     = 11'b010_0000_0000,
      ST_EMIT      = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_cnt_ff, step_cnt_in;
   logic              axis_ff, axis_in;
   logic              out_valid_ff, out_valid_in;
   logic              accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign step_idx  = step_cnt_ff;

   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      axis_in     = axis_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               state_in = ST_GYRO_P;
            end
         end
         ST_GYRO_P: begin
            cmd.corr_eval = 1'b1;
            cmd.mul_sel   = MUL_GYRO_X;
            state_in      = ST_GYRO_R;
         end
         ST_GYRO_R: begin
            cmd.pitch_gyro_upd = 1'b1;
            cmd.mul_sel        = MUL_GYRO_Z;
            state_in           = ST_GYRO_DONE;
         end
         ST_GYRO_DONE: begin
            cmd.roll_gyro_upd = 1'b1;
            if (status.corr) begin
               cmd.cordic_load = 1'b1;
               cmd.cordic_roll = 1'b0;
               axis_in         = 1'b0;
               step_cnt_in     = '0;
               state_in        = ST_CORDIC;
            end else begin
               state_in = ST_TEN_P;
            end
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (step_cnt_ff == LAST_STEP) begin
               state_in = ST_BLEND_A;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end
         ST_BLEND_A: begin
            cmd.mul_sel    = MUL_KEEP;
            cmd.blend_roll = axis_ff;
            state_in       = ST_BLEND_B;
         end
         ST_BLEND_B: begin
            cmd.blend_first = 1'b1;
            cmd.mul_sel     = MUL_ACC;
            state_in        = ST_BLEND_C;
         end
         ST_BLEND_C: begin
            cmd.blend_upd  = 1'b1;
            cmd.blend_roll = axis_ff;
            if (!axis_ff) begin
               cmd.cordic_load = 1'b1;
               cmd.cordic_roll = 1'b1;
               axis_in         = 1'b1;
               step_cnt_in     = '0;
               state_in        = ST_CORDIC;
            end else begin
               state_in = ST_TEN_P;
            end
         end
         ST_TEN_P: begin
            cmd.mul_sel = MUL_TEN_P;
            state_in    = ST_TEN_R;
         end
         ST_TEN_R: begin
            cmd.pitch_t_load = 1'b1;
            cmd.mul_sel      = MUL_TEN_R;
            state_in         = ST_EMIT;
         end
         ST_EMIT: begin
            if (!(out_valid_ff && rsp_stall)) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = cmd.emit || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         axis_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         axis_ff      <= axis_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(out_valid_ff && rsp_stall))
      else $error("result word overwritten while stalled");

   a_blend_only_with_corr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLEND_A) |-> status.corr)
      else $error("blend without accelerometer correction");

   a_step_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC) |-> (step_cnt_ff <= LAST_STEP))
      else $error("cordic step counter out of range");

   a_roll_blend_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_TEN_P) && ($past(state_ff) == ST_BLEND_C)) |-> axis_ff)
      else $error("conversion started before roll blend");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word taken while busy");

endmodule

[design/imucf_dpath.sv]
// datapath for the imu complementary filter: config registers, angle state,
// shared multiplier, cordic vectoring unit and result word; uses imucf_pkg
module imucf_dpath #(
   parameter int ANGLE_FRAC_BITS = imucf_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = imucf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [imucf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [imucf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  imucf_pkg::req_data_type              req_data,
   input  imucf_pkg::dp_cmd_type                cmd,
   input  logic [$clog2(CORDIC_STEPS)-1:0]      step_idx,
   output imucf_pkg::dp_status_type             status,
   output imucf_pkg::rsp_data_type              rsp_data
);
   import imucf_pkg::*;

   localparam int A_W = 34;
   localparam int B_W = 18;
   localparam int P_W = A_W + B_W;
   localparam int G_W = 60;
   localparam int C_W = 34;
   localparam int SHL = (ANGLE_FRAC_BITS >= 16) ? ANGLE_FRAC_BITS - 16 : 0;
   localparam int SHR = (ANGLE_FRAC_BITS < 16) ? 16 - ANGLE_FRAC_BITS : 0;
   localparam logic signed [C_W-1:0] HALF_TURN = C_W'(180) <<< ANGLE_FRAC_BITS;
   localparam logic signed [P_W-1:0] TEN_BIAS =
      (P_W'(1) <<< ANGLE_FRAC_BITS) - P_W'(1);
   localparam logic signed [P_W-1:0] TEN_HI = P_W'(327679);
   localparam logic signed [P_W-1:0] TEN_LO = -P_W'(327680);

   function automatic logic signed [31:0] sat_angle(input logic signed [G_W-1:0] v);
      if ((&v[G_W-1:31]) || !(|v[G_W-1:31])) begin
         return v[31:0];
      end
      return v[G_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   function automatic logic signed [19:0] ten_conv(input logic signed [P_W-1:0] p);
      logic signed [P_W-1:0] b;
      logic signed [P_W-1:0] t;
      b = p + (p[P_W-1] ? TEN_BIAS : P_W'(0));
      t = b >>> ANGLE_FRAC_BITS;
      if (t > TEN_HI) begin
         return TEN_HI[19:0];
      end
      if (t < TEN_LO) begin
         return TEN_LO[19:0];
      end
      return t[19:0];
   endfunction

   logic [15:0]              gyro_gain_ff;
   logic [16:0]              keep_weight_ff, mag_low_ff, mag_high_ff;
   req_data_type             sample_ff, sample_in;
   logic                     corr_ff, corr_in;
   logic signed [P_W-1:0]    prod_ff, prod_in, acc_sum_ff, acc_sum_in;
   logic signed [31:0]       pitch_ff, pitch_in, roll_ff, roll_in;
   logic signed [C_W-1:0]    cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic                     czero_ff, czero_in;
   logic signed [19:0]       pitch_t_ff, pitch_t_in;
   rsp_data_type             out_ff, out_in;

   logic [16:0]              abs_x, abs_y, abs_z;
   logic [17:0]              mag;
   logic [16:0]              k_eff, k_rest;
   logic signed [A_W-1:0]    mul_a;
   logic signed [B_W-1:0]    mul_b;
   logic signed [P_W-1:0]    prod;
   logic signed [G_W-1:0]    gprod, gyro_step, pitch_sum, roll_diff, blend_val;
   logic signed [P_W:0]      blend_sum;
   logic signed [31:0]       blend_old;
   logic signed [16:0]       x0, y0, x1, y1;
   logic signed [C_W-1:0]    dx, dy, sa;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_gain_ff   <= GYRO_GAIN_RST;
         keep_weight_ff <= KEEP_WEIGHT_RST;
         mag_low_ff     <= MAG_LOW_RST;
         mag_high_ff    <= MAG_HIGH_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_GYRO_GAIN:   gyro_gain_ff   <= csr_wdata[15:0];
            CSR_KEEP_WEIGHT: keep_weight_ff <= csr_wdata;
            CSR_MAG_LOW:     mag_low_ff     <= csr_wdata;
            CSR_MAG_HIGH:    mag_high_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // magnitude gate
   assign abs_x = sample_ff.accel_x[15] ? 17'(-17'(sample_ff.accel_x)) : 17'(sample_ff.accel_x);
   assign abs_y = sample_ff.accel_y[15] ? 17'(-17'(sample_ff.accel_y)) : 17'(sample_ff.accel_y);
   assign abs_z = sample_ff.accel_z[15] ? 17'(-17'(sample_ff.accel_z)) : 17'(sample_ff.accel_z);
   assign mag   = 18'(abs_x) + 18'(abs_y) + 18'(abs_z);

   assign sample_in = cmd.capture ? req_data : sample_ff;
   assign corr_in   = cmd.corr_eval ? ((mag > {1'b0, mag_low_ff}) && (mag < {1'b0, mag_high_ff}))
                                    : corr_ff;
   assign status.corr = corr_ff;

   // shared multiplier
   assign k_eff     = (keep_weight_ff > KEEP_MAX) ? KEEP_MAX : keep_weight_ff;
   assign k_rest    = KEEP_MAX - k_eff;
   assign blend_old = cmd.blend_roll ? roll_ff : pitch_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_GYRO_X: begin
            mul_a = A_W'(sample_ff.gyro_x);
            mul_b = $signed({2'b00, gyro_gain_ff});
         end
         MUL_GYRO_Z: begin
            mul_a = A_W'(sample_ff.gyro_z);
            mul_b = $signed({2'b00, gyro_gain_ff});
         end
         MUL_KEEP: begin
            mul_a = A_W'(blend_old);
            mul_b = $signed({1'b0, k_eff});
         end
         MUL_ACC: begin
            mul_a = czero_ff ? A_W'(0) : cz_ff;
            mul_b = $signed({1'b0, k_rest});
         end
         MUL_TEN_P: begin
            mul_a = A_W'(pitch_ff);
            mul_b = B_W'(10);
         end
         MUL_TEN_R: begin
            mul_a = A_W'(roll_ff);
            mul_b = B_W'(10);
         end
         default: begin
         end
      endcase
   end

   assign prod       = mul_a * mul_b;
   assign prod_in    = (cmd.mul_sel != MUL_NONE) ? prod : prod_ff;
   assign acc_sum_in = cmd.blend_first ? prod_ff : acc_sum_ff;

   // angle updates
   assign gprod     = G_W'(prod_ff);
   assign gyro_step = (ANGLE_FRAC_BITS >= 16) ? (gprod <<< SHL) : (gprod >>> SHR);
   assign pitch_sum = G_W'(pitch_ff) + gyro_step;
   assign roll_diff = G_W'(roll_ff) - gyro_step;
   assign blend_sum = (P_W+1)'(acc_sum_ff) + (P_W+1)'(prod_ff);
   assign blend_val = G_W'(blend_sum >>> 16);

   always_comb begin
      pitch_in = pitch_ff;
      roll_in  = roll_ff;
      if (cmd.pitch_gyro_upd) begin
         pitch_in = sat_angle(pitch_sum);
      end
      if (cmd.roll_gyro_upd) begin
         roll_in = sat_angle(roll_diff);
      end
      if (cmd.blend_upd && !cmd.blend_roll) begin
         pitch_in = sat_angle(blend_val);
      end
      if (cmd.blend_upd && cmd.blend_roll) begin
         roll_in = sat_angle(blend_val);
      end
   end

   // cordic vectoring unit
   assign x0 = cmd.cordic_roll ? -17'(sample_ff.accel_y) : 17'(sample_ff.accel_z);
   assign y0 = cmd.cordic_roll ? 17'(sample_ff.accel_x) : 17'(sample_ff.accel_y);
   assign x1 = x0[16] ? -x0 : x0;
   assign y1 = x0[16] ? -y0 : y0;
   assign dx = cx_ff >>> step_idx;
   assign dy = cy_ff >>> step_idx;
   assign sa = C_W'($signed(step_angle(5'(step_idx), ANGLE_FRAC_BITS)));

   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      czero_in = czero_ff;
      if (cmd.cordic_load) begin
         cx_in    = C_W'(x1) <<< 14;
         cy_in    = C_W'(y1) <<< 14;
         cz_in    = x0[16] ? (y0[16] ? -HALF_TURN : HALF_TURN) : C_W'(0);
         czero_in = (x0 == '0) && (y0 == '0);
      end else if (cmd.cordic_step) begin
         if (!cy_ff[C_W-1] && (cy_ff != '0)) begin
            cx_in = cx_ff + dy;
            cy_in = cy_ff - dx;
            cz_in = cz_ff + sa;
         end else begin
            cx_in = cx_ff - dy;
            cy_in = cy_ff + dx;
            cz_in = cz_ff - sa;
         end
      end
   end

   // tenths and result word
   assign pitch_t_in = cmd.pitch_t_load ? ten_conv(prod_ff) : pitch_t_ff;

   always_comb begin
      out_in = out_ff;
      if (cmd.emit) begin
         out_in.pitch_tenths       = pitch_t_ff;
         out_in.roll_tenths        = ten_conv(prod_ff);
         out_in.correction_applied = corr_ff;
      end
   end

   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= '0;
         roll_ff  <= '0;
         corr_ff  <= 1'b0;
      end else begin
         pitch_ff <= pitch_in;
         roll_ff  <= roll_in;
         corr_ff  <= corr_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      prod_ff    <= prod_in;
      acc_sum_ff <= acc_sum_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      cz_ff      <= cz_in;
      czero_ff   <= czero_in;
      pitch_t_ff <= pitch_t_in;
      out_ff     <= out_in;
   end

endmodule

[design/imu_complementary_filter_unit.sv]
// Complementary pitch/roll filter. Each accepted sample word integrates the
// gyro rates into the pitch and roll angles and, when the summed absolute
// acceleration lies strictly between magnitude_low and magnitude_high, blends
// each angle toward an accelerometer angle from a CORDIC atan2. One result
// word per sample. The block takes no new sample until it is done with the
// current one, and a sample with correction holds it longer: the two atan2
// runs share one CORDIC vectoring unit, and the single shared multiplier is
// used for gyro scaling, blending and tenths conversion. The result word sits
// in an output register, so the next sample is taken while it waits.
// Configuration writes are taken in any cycle and must occur while idle.
// top level; uses imucf_pkg, imucf_ctrl, imucf_dpath
module imu_complementary_filter_unit #(
   parameter int ANGLE_FRAC_BITS = imucf_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = imucf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  imucf_pkg::req_data_type          req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output imucf_pkg::rsp_data_type          rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [imucf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [imucf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import imucf_pkg::*;

   dp_cmd_type                      cmd;
   dp_status_type                   status;
   logic [$clog2(CORDIC_STEPS)-1:0] step_idx;

   assign csr_ready = 1'b1;

   imucf_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .step_idx  (step_idx)
   );

   imucf_dpath #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .step_idx  (step_idx),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
